// ----- sv/gcc_pkg.sv -----
// Shared types, constants and helpers for the granular contact counter.
// No dependencies; used by the contact pipeline, the counter and the top level.
package gcc_pkg;

  // Storage sizing
  localparam int COLUMNS    = 4;
  localparam int COUNT_BITS = 8;
  localparam int OUT_FIELDS = 4;
  localparam int BOUND_COLS = 4;
  localparam int FIELD_BITS = 8;
  localparam int USED_BITS  = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Stream widths
  localparam int IN_DATA_BITS  = 264;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = OUT_FIELDS * FIELD_BITS;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLUMNS_USED = 2'd0;
  localparam logic [1:0] CFG_TYPE_LOW     = 2'd1;
  localparam logic [1:0] CFG_TYPE_HIGH    = 2'd2;

  // Configuration reset values
  localparam logic [2:0]  COLUMNS_USED_RST = 3'd1;
  localparam logic [31:0] TYPE_LOW_RST     = 32'h0101_0101;
  localparam logic [31:0] TYPE_HIGH_RST    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  columns_used;
    logic [31:0] type_low;
    logic [31:0] type_high;
  } cfg_t;

  // One neighbour pair as captured at the input
  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] center_radius;
    logic [31:0] other_x;
    logic [31:0] other_y;
    logic [31:0] other_z;
    logic [30:0] other_radius;
    logic [7:0]  other_type;
    logic        in_group;
    logic        pair_valid;
    logic        last_pair;
  } pair_t;

  // Side information that travels with a pair down the pipeline
  typedef struct packed {
    logic [7:0] other_type;
    logic       in_group;
    logic       pair_valid;
    logic       last_pair;
  } pair_ctrl_t;

  // Contact decision handed to the counter
  typedef struct packed {
    logic       hit;
    logic [7:0] other_type;
    logic       in_group;
    logic       last_pair;
  } contact_t;

  // Magnitude of the difference of two signed 32-bit coordinates
  function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic [32:0] d;
    logic [32:0] m;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? (33'd0 - d) : d;
    return m[31:0];
  endfunction

endpackage

// ----- sv/granular_contact_counter.sv -----
// Top level of the granular contact counter: configuration registers and streams.
// Depends on gcc_pkg, gcc_contact_pipe and gcc_counter.

// The block takes one neighbour pair per clock, unless back-pressure stalls
// the pipeline, and returns one result, the contact counts of all four
// columns, for each pair marked tlast. A pair passes the four-stage contact
// pipeline (input register, coordinate differences, 32x32 squares, exact sum
// and compare) and then the counter stage, which loads the result into the
// output register when it takes the last pair. Pairs that are not last keep
// moving while a result waits at the output; only a last pair waits for the
// output register. Configuration has its own channel, which is always ready.
module granular_contact_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // center_x, center_y, center_z, center_radius, other_x, other_y, other_z,
  // other_radius, other_type (from bit 0 up), zero padded
  input  logic [gcc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // in_group, pair_valid (from bit 0 up)
  input  logic [gcc_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // count_col0, count_col1, count_col2, count_col3 (from bit 0 up)
  output logic [gcc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  gcc_pkg::cfg_t     cfg_q;
  gcc_pkg::pair_t    in_pair;
  gcc_pkg::contact_t d_contact;
  logic d_valid, d_ready;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns_used <= gcc_pkg::COLUMNS_USED_RST;
      cfg_q.type_low     <= gcc_pkg::TYPE_LOW_RST;
      cfg_q.type_high    <= gcc_pkg::TYPE_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gcc_pkg::CFG_COLUMNS_USED: cfg_q.columns_used <= cfg_data_i[2:0];
        gcc_pkg::CFG_TYPE_LOW:     cfg_q.type_low     <= cfg_data_i;
        gcc_pkg::CFG_TYPE_HIGH:    cfg_q.type_high    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input stream
  assign in_pair.center_x      = s_axis_tdata[31:0];
  assign in_pair.center_y      = s_axis_tdata[63:32];
  assign in_pair.center_z      = s_axis_tdata[95:64];
  assign in_pair.center_radius = s_axis_tdata[126:96];
  assign in_pair.other_x       = s_axis_tdata[158:127];
  assign in_pair.other_y       = s_axis_tdata[190:159];
  assign in_pair.other_z       = s_axis_tdata[222:191];
  assign in_pair.other_radius  = s_axis_tdata[253:223];
  assign in_pair.other_type    = s_axis_tdata[261:254];
  assign in_pair.in_group      = s_axis_tuser[0];
  assign in_pair.pair_valid    = s_axis_tuser[1];
  assign in_pair.last_pair     = s_axis_tlast;

  gcc_contact_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_pair_i     (in_pair),
    .out_valid_o   (d_valid),
    .out_ready_i   (d_ready),
    .out_contact_o (d_contact)
  );

  gcc_counter u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (d_valid),
    .in_ready_o   (d_ready),
    .in_contact_i (d_contact),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

  // A stalled contact decision is held for the counter
  a_hold_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid && !d_ready) |=> (d_valid && $stable(d_contact)))
    else $error("contact decision changed while stalled");

  // A last pair always produces a result
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid && d_ready && d_contact.last_pair) |=> m_axis_tvalid)
    else $error("last pair gave no result");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !(d_valid && d_ready && d_contact.last_pair))
    else $error("pending result overwritten");

  // A particle outside the group reports zero counts
  a_group_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid && d_ready && d_contact.last_pair && !d_contact.in_group)
      |=> (m_axis_tdata == '0))
    else $error("nonzero counts for particle outside group");

endmodule

// ----- sv/gcc_contact_pipe.sv -----
// Contact test pipeline: input register, differences, squares, compare.
// Depends on gcc_pkg for the pair and contact types.
module gcc_contact_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gcc_pkg::pair_t        in_pair_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gcc_pkg::contact_t     out_contact_o
);

  // Stage valids
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  logic en_a, en_b, en_c, en_d;

  // Stage A: captured request
  gcc_pkg::pair_t a_q;

  // Stage B: coordinate magnitudes and radius sum
  logic [31:0] dx_q, dy_q, dz_q, rs_q;
  gcc_pkg::pair_ctrl_t b_ctrl_q;

  // Stage C: squares and contact limit
  logic [63:0] sx_q, sy_q, sz_q, lim_q;
  gcc_pkg::pair_ctrl_t c_ctrl_q;

  // Stage D: decision
  gcc_pkg::contact_t d_q;

  logic [65:0] dist_sum;
  logic        touch;

  // Advance each stage when it is empty or its content moves on
  assign en_d = !d_valid_q || out_ready_i;
  assign en_c = !c_valid_q || en_d;
  assign en_b = !b_valid_q || en_c;
  assign en_a = !a_valid_q || en_b;
  assign in_ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (en_a) a_valid_q <= in_valid_i;
      if (en_b) b_valid_q <= a_valid_q;
      if (en_c) c_valid_q <= b_valid_q;
      if (en_d) d_valid_q <= c_valid_q;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= in_pair_i;
  end

  // Differences and radius sum
  always_ff @(posedge clk_i) begin
    if (en_b) begin
      dx_q <= gcc_pkg::abs_diff(a_q.center_x, a_q.other_x);
      dy_q <= gcc_pkg::abs_diff(a_q.center_y, a_q.other_y);
      dz_q <= gcc_pkg::abs_diff(a_q.center_z, a_q.other_z);
      rs_q <= {1'b0, a_q.center_radius} + {1'b0, a_q.other_radius};
      b_ctrl_q.other_type <= a_q.other_type;
      b_ctrl_q.in_group   <= a_q.in_group;
      b_ctrl_q.pair_valid <= a_q.pair_valid;
      b_ctrl_q.last_pair  <= a_q.last_pair;
    end
  end

  // Square the magnitudes and the radius sum
  always_ff @(posedge clk_i) begin
    if (en_c) begin
      sx_q     <= 64'(dx_q) * 64'(dx_q);
      sy_q     <= 64'(dy_q) * 64'(dy_q);
      sz_q     <= 64'(dz_q) * 64'(dz_q);
      lim_q    <= 64'(rs_q) * 64'(rs_q);
      c_ctrl_q <= b_ctrl_q;
    end
  end

  // Exact sum with carries, then compare against the limit
  assign dist_sum = {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
  assign touch    = (dist_sum <= {2'b00, lim_q});

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      d_q.hit        <= touch && c_ctrl_q.in_group && c_ctrl_q.pair_valid;
      d_q.other_type <= c_ctrl_q.other_type;
      d_q.in_group   <= c_ctrl_q.in_group;
      d_q.last_pair  <= c_ctrl_q.last_pair;
    end
  end

  assign out_valid_o   = d_valid_q;
  assign out_contact_o = d_q;

endmodule

// ----- sv/gcc_counter.sv -----
// Per-column saturating contact counters and the result register.
// Depends on gcc_pkg for the configuration and contact types.
module gcc_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gcc_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  gcc_pkg::contact_t                 in_contact_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gcc_pkg::OUT_DATA_BITS-1:0] out_data_o
);

  logic [gcc_pkg::COUNT_BITS-1:0] cnt_q [gcc_pkg::COLUMNS];
  logic [gcc_pkg::COUNT_BITS-1:0] cnt_d [gcc_pkg::COLUMNS];
  logic [gcc_pkg::COUNT_BITS-1:0] cnt_upd [gcc_pkg::COLUMNS];
  logic [gcc_pkg::OUT_DATA_BITS-1:0] res_q, res_d;
  logic out_valid_q;
  logic out_free, go, emit;
  logic [gcc_pkg::USED_BITS-1:0] used;

  // A non-last request never needs the result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_contact_i.last_pair || out_free;
  assign go         = in_valid_i && in_ready_o;
  assign emit       = go && in_contact_i.last_pair;

  // Clamp the column count to the storage
  assign used = ({1'b0, cfg_i.columns_used} > gcc_pkg::USED_BITS'(gcc_pkg::COLUMNS))
              ? gcc_pkg::USED_BITS'(gcc_pkg::COLUMNS)
              : {1'b0, cfg_i.columns_used};

  // Count matching columns, build the result, clear on the last pair
  always_comb begin
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] ext;
    for (int m = 0; m < gcc_pkg::COLUMNS; m++) begin
      lo = cfg_i.type_low[(m % gcc_pkg::BOUND_COLS) * 8 +: 8];
      hi = cfg_i.type_high[(m % gcc_pkg::BOUND_COLS) * 8 +: 8];
      cnt_upd[m] = cnt_q[m];
      if (go && in_contact_i.hit && (gcc_pkg::USED_BITS'(m) < used)
          && (m < gcc_pkg::BOUND_COLS) && (in_contact_i.other_type >= lo)
          && (in_contact_i.other_type <= hi) && (cnt_q[m] != gcc_pkg::COUNT_MAX)) begin
        cnt_upd[m] = cnt_q[m] + 1'b1;
      end
      cnt_d[m] = emit ? '0 : cnt_upd[m];
    end
    res_d = '0;
    for (int j = 0; j < gcc_pkg::OUT_FIELDS; j++) begin
      ext = '0;
      if ((j < gcc_pkg::COLUMNS) && in_contact_i.in_group
          && (gcc_pkg::USED_BITS'(j) < used)) begin
        ext = 16'(cnt_upd[j % gcc_pkg::COLUMNS]);
      end
      res_d[j*gcc_pkg::FIELD_BITS +: gcc_pkg::FIELD_BITS] =
        (ext > 16'd255) ? 8'hFF : ext[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int m = 0; m < gcc_pkg::COLUMNS; m++) cnt_q[m] <= '0;
    end else begin
      for (int m = 0; m < gcc_pkg::COLUMNS; m++) cnt_q[m] <= cnt_d[m];
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (emit) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

// ----- bench/granular_contact_counter_test.sv -----
// Self-checking bench for granular_contact_counter: streams neighbour pairs and
// checks every count result against an exact contact-count predictor.
// Depends on gcc_pkg and the granular_contact_counter RTL.
`timescale 1ns / 100ps

// Predicts contact counts per centre particle and holds the results still due
class contact_tally;
  logic [2:0]                           cols_used;
  logic [31:0]                          low_bytes;
  logic [31:0]                          high_bytes;
  logic [gcc_pkg::COUNT_BITS-1:0]       tally [gcc_pkg::COLUMNS];
  logic [gcc_pkg::OUT_DATA_BITS-1:0]    expected_q [$];
  int                                   mismatches;

  function new();
    cols_used  = gcc_pkg::COLUMNS_USED_RST;
    low_bytes  = gcc_pkg::TYPE_LOW_RST;
    high_bytes = gcc_pkg::TYPE_HIGH_RST;
    foreach (tally[m]) tally[m] = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      gcc_pkg::CFG_COLUMNS_USED: cols_used  = data[2:0];
      gcc_pkg::CFG_TYPE_LOW:     low_bytes  = data;
      gcc_pkg::CFG_TYPE_HIGH:    high_bytes = data;
      default: ;
    endcase
  endfunction

  // Exact magnitude of a signed coordinate difference
  function logic [32:0] span(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [33:0] d;
    d = a - b;
    if (d < 0) d = -d;
    return d[32:0];
  endfunction

  // Touch when dx^2 + dy^2 + dz^2 <= (ra + rb)^2, all kept at full width
  function bit touches(gcc_pkg::pair_t p);
    logic [32:0] dx, dy, dz, reach;
    logic [65:0] dist2, reach2;
    dx     = span(p.center_x, p.other_x);
    dy     = span(p.center_y, p.other_y);
    dz     = span(p.center_z, p.other_z);
    reach  = {2'b0, p.center_radius} + {2'b0, p.other_radius};
    dist2  = {33'b0, dx} * {33'b0, dx} + {33'b0, dy} * {33'b0, dy}
           + {33'b0, dz} * {33'b0, dz};
    reach2 = {33'b0, reach} * {33'b0, reach};
    return dist2 <= reach2;
  endfunction

  // Advance the running counts for one accepted request; queue a result on last
  function void note_pair(gcc_pkg::pair_t p);
    int used;
    int v;
    logic [gcc_pkg::OUT_DATA_BITS-1:0] counts;
    used = (cols_used > gcc_pkg::COLUMNS) ? gcc_pkg::COLUMNS : cols_used;
    if (p.in_group && p.pair_valid && touches(p)) begin
      for (int m = 0; m < used && m < gcc_pkg::BOUND_COLS; m++) begin
        if (p.other_type >= low_bytes[8*m +: 8] && p.other_type <= high_bytes[8*m +: 8]
            && tally[m] != gcc_pkg::COUNT_MAX) begin
          tally[m]++;
        end
      end
    end
    if (p.last_pair) begin
      counts = '0;
      for (int j = 0; j < gcc_pkg::OUT_FIELDS; j++) begin
        if (p.in_group && j < used) begin
          v = tally[j];
          if (v > 255) v = 255;
          counts[8*j +: 8] = v[7:0];
        end
      end
      expected_q.push_back(counts);
      foreach (tally[m]) tally[m] = '0;
    end
  endfunction

  // Compare one result against the oldest expectation, field by field
  function void check_counts(logic [gcc_pkg::OUT_DATA_BITS-1:0] got);
    logic [gcc_pkg::OUT_DATA_BITS-1:0] want;
    if (expected_q.size() == 0) begin
      if (mismatches < 10) $display("%0t: unexpected result %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    for (int j = 0; j < gcc_pkg::OUT_FIELDS; j++) begin
      if (got[8*j +: 8] != want[8*j +: 8]) begin
        if (mismatches < 10) begin
          $display("%0t: count_col%0d expected %0d got %0d", $time, j,
                   want[8*j +: 8], got[8*j +: 8]);
        end
        mismatches++;
      end
    end
  endfunction
endclass

module granular_contact_counter_test;

  localparam logic [30:0] RAD_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam logic [31:0] MINUS_1 = 32'hFFFF_FFFF;

  logic                              clk_i;
  logic                              rst_ni;
  logic [gcc_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;
  logic [gcc_pkg::IN_USER_BITS-1:0]  s_axis_tuser;
  logic                              s_axis_tlast;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [gcc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [1:0]                        cfg_index_i;
  logic [31:0]                       cfg_data_i;

  contact_tally board;
  int send_idle_pct;
  int recv_idle_pct;
  int epoch;

  granular_contact_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Check accepted results and stall the output at random
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) board.check_counts(m_axis_tdata);
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  function gcc_pkg::pair_t mk_pair(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                   logic [30:0] crad, logic [31:0] ox, logic [31:0] oy,
                                   logic [31:0] oz, logic [30:0] orad, logic [7:0] ty,
                                   bit grp, bit valid, bit last);
    gcc_pkg::pair_t p;
    p.center_x = cx;  p.center_y = cy;  p.center_z = cz;  p.center_radius = crad;
    p.other_x  = ox;  p.other_y  = oy;  p.other_z  = oz;  p.other_radius  = orad;
    p.other_type = ty;
    p.in_group   = grp;
    p.pair_valid = valid;
    p.last_pair  = last;
    return p;
  endfunction

  // Random types half the time, else a type on or next to a configured bound
  function logic [7:0] pick_type();
    int k;
    k = $urandom_range(3);
    case ($urandom_range(3))
      0:       return board.low_bytes[8*k +: 8] + 8'($urandom_range(2)) - 8'd1;
      1:       return board.high_bytes[8*k +: 8] + 8'($urandom_range(2)) - 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Hold one request until accepted, after an optional random gap
  task send_pair(gcc_pkg::pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b0, p.other_type, p.other_radius, p.other_z, p.other_y, p.other_x,
                      p.center_radius, p.center_z, p.center_y, p.center_x};
    s_axis_tuser  <= {p.pair_valid, p.in_group};
    s_axis_tlast  <= p.last_pair;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(p);
  endtask

  task stop_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every pending result, then let the pipeline empty
  task drain();
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
  endtask

  task set_config(logic [31:0] cols, logic [31:0] lo, logic [31:0] hi);
    drain();
    write_reg(gcc_pkg::CFG_COLUMNS_USED, cols);
    write_reg(gcc_pkg::CFG_TYPE_LOW, lo);
    write_reg(gcc_pkg::CFG_TYPE_HIGH, hi);
    cfg_valid_i <= 1'b0;
  endtask

  // Early epochs walk every column count and the bound extremes
  task random_config(int e);
    logic [31:0] cols, lo, hi;
    logic [7:0]  a, b;
    cols = $urandom;
    cols[2:0] = (e < 8) ? 3'((e * 5) % 8) : 3'($urandom_range(7));
    case (e)
      0: begin lo = '0;       hi = '1; end
      1: begin lo = '0;       hi = '0; end
      2: begin lo = '1;       hi = '1; end
      3: begin lo = '1;       hi = '0; end
      default: begin
        for (int m = 0; m < gcc_pkg::BOUND_COLS; m++) begin
          a = 8'($urandom);
          b = 8'($urandom);
          case ($urandom_range(5))
            0: begin
              // empty range
              b = 8'($urandom_range(254));
              a = 8'($urandom_range(255, b + 1));
            end
            1: b = a;
            default: if (a > b) {a, b} = {b, a};
          endcase
          lo[8*m +: 8] = a;
          hi[8*m +: 8] = b;
        end
      end
    endcase
    set_config(cols, lo, hi);
  endtask

  // One centre particle: pairs clustered around it, with some noise items
  task send_atom(int size);
    gcc_pkg::pair_t p;
    logic [31:0]    cx, cy, cz;
    logic [30:0]    crad;
    bit             grp;
    int             scale;
    cx   = $urandom;
    cy   = $urandom;
    cz   = $urandom;
    crad = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 20));
    grp  = $urandom_range(9) != 0;
    for (int i = 0; i < size; i++) begin
      p.center_x      = cx;
      p.center_y      = cy;
      p.center_z      = cz;
      p.center_radius = crad;
      p.in_group      = ($urandom_range(19) == 0) ? !grp : grp;
      p.pair_valid    = $urandom_range(19) != 0;
      p.last_pair     = (i == size - 1);
      p.other_type    = pick_type();
      if ($urandom_range(9) == 0) begin
        p.other_x      = $urandom;
        p.other_y      = $urandom;
        p.other_z      = $urandom;
        p.other_radius = 31'($urandom);
      end else begin
        scale          = 1 << (16 + 2 * $urandom_range(2));
        p.other_x      = cx + $urandom_range(2 * scale) - scale;
        p.other_y      = cy + $urandom_range(2 * scale) - scale;
        p.other_z      = cz + $urandom_range(2 * scale) - scale;
        p.other_radius = 31'($urandom_range(1 << 20));
      end
      send_pair(p);
    end
  endtask

  task run_epoch(int n);
    int sent;
    int size;
    sent = 0;
    while (sent < n) begin
      size = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 1);
      send_atom(size);
      sent += size;
    end
    stop_stream();
  endtask

  // Geometry edges, bounds, missing neighbour and group cases at reset settings
  task directed_pairs();
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 8'd1, 1, 1, 0));
    send_pair(mk_pair(0, 0, 0, 2, 3, 4, 0, 3, 8'd255, 1, 1, 0));
    send_pair(mk_pair(0, 0, 0, 2, 3, 4, 1, 3, 8'd7, 1, 1, 0));
    send_pair(mk_pair(0, 0, 0, 9, 1, 1, 1, 9, 8'd0, 1, 1, 1));
    // widest spread: sum of squares overflows 64 bits
    send_pair(mk_pair(NEG_MAX, POS_MAX, NEG_MAX, RAD_MAX,
                      POS_MAX, NEG_MAX, POS_MAX, RAD_MAX, 8'hFF, 1, 1, 1));
    send_pair(mk_pair(NEG_MAX, NEG_MAX, NEG_MAX, RAD_MAX,
                      NEG_MAX, NEG_MAX, NEG_MAX, RAD_MAX, 8'hFF, 1, 1, 0));
    // last item without a neighbour still emits
    send_pair(mk_pair(POS_MAX, POS_MAX, POS_MAX, 0, POS_MAX, POS_MAX, POS_MAX, 0,
                      8'h80, 1, 0, 1));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 8'd1, 1, 0, 1));
    // centre outside group counts nothing and reports zero
    send_pair(mk_pair(5, 5, 5, 1, 5, 5, 5, 1, 8'd1, 0, 1, 0));
    send_pair(mk_pair(5, 5, 5, 1, 5, 5, 5, 1, 8'd1, 1, 1, 1));
    send_pair(mk_pair(5, 5, 5, 1, 5, 5, 5, 1, 8'd2, 1, 1, 0));
    send_pair(mk_pair(5, 5, 5, 1, 5, 5, 5, 1, 8'd2, 0, 1, 1));
    send_pair(mk_pair(5, 5, 5, 1, 5, 5, 5, 1, 8'd3, 1, 0, 1));
    send_pair(mk_pair(MINUS_1, MINUS_1, MINUS_1, 2, 1, 1, 1, 2, 8'hFE, 1, 1, 1));
    send_pair(mk_pair(0, 0, 0, RAD_MAX, POS_MAX, 0, 0, 0, 8'd1, 1, 1, 1));
    stop_stream();
  endtask

  initial begin
    gcc_pkg::pair_t sat_pair;
    logic [31:0]    sat_pos;
    board         = new();
    send_idle_pct = 11;
    recv_idle_pct = 71;
    epoch         = 0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = gcc_pkg::CFG_COLUMNS_USED;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_pairs();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 11; recv_idle_pct = 71; end
        1:       begin send_idle_pct = 71; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      if (ph == 2) begin
        // drive one atom past the counter limit in every column
        set_config({29'($urandom), 3'd4}, '0, '1);
        sat_pos = $urandom;
        for (int i = 0; i < 270; i++) begin
          sat_pair = mk_pair(sat_pos, sat_pos, sat_pos, 0, sat_pos, sat_pos, sat_pos, 0,
                             8'($urandom), 1, 1, i == 269);
          send_pair(sat_pair);
        end
        stop_stream();
      end
      for (int k = 0; k < 4; k++) begin
        random_config(epoch);
        epoch++;
        run_epoch(70);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("[granular_contact_counter] OK");
    end else begin
      $display("[granular_contact_counter] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[granular_contact_counter] ERROR");
    $finish;
  end

endmodule

// ----- granular_contact_counter.f -----
sv/gcc_pkg.sv
sv/gcc_contact_pipe.sv
sv/gcc_counter.sv
sv/granular_contact_counter.sv
bench/granular_contact_counter_test.sv
